>>> hdl/planar_packbits_image_decoder_top_assert.svh
// Assertion macros for the planar image data decoder.
`ifndef PLANAR_PACKBITS_IMAGE_DECODER_TOP_ASSERT_SVH
`define PLANAR_PACKBITS_IMAGE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ppid_pkg.sv
// Shared types, codes and helper functions of the planar image data decoder.
package ppid_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMPRESSION_MODE = 3'd0,
    REG_ONE_BIT_PIXELS   = 3'd1,
    REG_CHAN_LAYOUT      = 3'd2,
    REG_IMAGE_COLUMNS    = 3'd3,
    REG_IMAGE_ROWS       = 3'd4,
    REG_PLANE_COUNT      = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CM_BITMAP  = 3'd0,
    CM_GRAY    = 3'd1,
    CM_INDEXED = 3'd2,
    CM_RGB     = 3'd3,
    CM_CMYK    = 3'd4
  } color_e;

  typedef enum logic [2:0] {
    TGT_RED     = 3'd0,
    TGT_GREEN   = 3'd1,
    TGT_BLUE    = 3'd2,
    TGT_ALPHA   = 3'd3,
    TGT_GRAY    = 3'd4,
    TGT_PALETTE = 3'd5,
    TGT_DISCARD = 3'd6
  } target_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  // Reset values of the configuration registers.
  localparam logic        RST_COMPRESSION = 1'b0;
  localparam logic        RST_ONE_BIT     = 1'b0;
  localparam logic [2:0]  RST_CHAN_LAYOUT = 3'd3;
  localparam logic [14:0] RST_COLUMNS     = 15'd1;
  localparam logic [14:0] RST_ROWS        = 15'd1;
  localparam logic [5:0]  RST_PLANES      = 6'd3;

  // PackBits header codes and pixel values.
  localparam logic [7:0] HDR_NOOP      = 8'h80;
  localparam logic [8:0] REPEAT_BASE   = 9'd257;
  localparam logic [7:0] PIX_SET_BIT   = 8'd0;
  localparam logic [7:0] PIX_CLEAR_BIT = 8'd255;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic        compression_mode;
    logic        one_bit_pixels;
    logic [2:0]  chan_layout;
    logic [14:0] image_columns;
    logic [14:0] image_rows;
    logic [5:0]  plane_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic [14:0] row_index;
    logic [14:0] column_start;
    logic [7:0]  span_length;
    logic [7:0]  pixel_value;
    target_e     target_kind;
    logic        image_done;
    logic        last_of_item;
  } out_word_t;

  // One decoded byte's worth of output: a first span plus, in one-bit
  // mode, the remaining pixel bits to step through.
  typedef struct packed {
    logic [14:0] row;
    logic [14:0] col;
    logic [7:0]  len;
    logic [7:0]  pix;
    target_e     tgt;
    logic [7:0]  bits;
    logic [3:0]  count;
    logic        done;
  } job_t;

  function automatic target_e plane_target(logic [2:0] mode, logic [5:0] plane);
    target_e t;
    case (color_e'(mode))
      CM_CMYK: begin
        if (plane == 6'd3 || plane > 6'd4) t = TGT_DISCARD;
        else if (plane < 6'd3)             t = target_e'(plane[2:0]);
        else                               t = TGT_ALPHA;
      end
      CM_BITMAP, CM_GRAY: t = (plane == 6'd0) ? TGT_GRAY : TGT_ALPHA;
      CM_INDEXED:         t = (plane == 6'd0) ? TGT_PALETTE : TGT_ALPHA;
      CM_RGB:             t = (plane < 6'd3) ? target_e'(plane[2:0]) : TGT_ALPHA;
      default:            t = TGT_DISCARD;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/ppid_decoder.sv
// Position tracking and raw / PackBits decoding of one data word per cycle while input is accepted.
module ppid_decoder import ppid_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_word_t in_data_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  logic [5:0]  plane_q, plane_d;
  logic [14:0] row_q, row_d;
  logic [14:0] col_q, col_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  lit_q, lit_d;
  logic [7:0]  rep_q, rep_d;
  logic        done_q, done_d;

  logic [7:0]  b;
  logic        clr;
  logic [5:0]  pl_c;
  logic [14:0] row_c, col_c;
  phase_e      phase_c;
  logic [7:0]  lit_c, rep_c;
  logic        done_c;

  logic        full, row_last, pl_last;
  logic [14:0] adv_col, adv_row;
  logic [5:0]  adv_pl;
  logic        adv_done;
  logic        raw;
  logic [14:0] e_col, e_row;
  logic [5:0]  e_pl;
  logic        e_row_last, e_pl_last;
  logic [14:0] room;
  logic        in_row;
  logic [3:0]  bit_n;
  logic [7:0]  rep_len;

  assign b   = in_data_i.data_byte;
  assign clr = in_data_i.first_byte;

  // A first word starts the image over before it is decoded.
  assign pl_c    = clr ? '0 : plane_q;
  assign row_c   = clr ? '0 : row_q;
  assign col_c   = clr ? '0 : col_q;
  assign phase_c = clr ? PH_HEADER : phase_q;
  assign lit_c   = clr ? '0 : lit_q;
  assign rep_c   = clr ? '0 : rep_q;
  assign done_c  = clr ? 1'b0 : done_q;

  // Deferred advance of a full row.
  assign full     = col_c >= cfg_i.image_columns;
  assign row_last = (16'(row_c) + 16'd1) >= 16'(cfg_i.image_rows);
  assign pl_last  = (7'(pl_c) + 7'd1) >= 7'(cfg_i.plane_count);
  assign adv_col  = full ? '0 : col_c;
  assign adv_row  = full ? (row_last ? '0 : row_c + 15'd1) : row_c;
  assign adv_pl   = (full && row_last && !pl_last) ? pl_c + 6'd1 : pl_c;
  assign adv_done = full && row_last && pl_last;

  // Raw words are written at the advanced position, run bytes in place.
  assign raw        = !cfg_i.compression_mode;
  assign e_col      = raw ? adv_col : col_c;
  assign e_row      = raw ? adv_row : row_c;
  assign e_pl       = raw ? adv_pl  : pl_c;
  assign e_row_last = (16'(e_row) + 16'd1) >= 16'(cfg_i.image_rows);
  assign e_pl_last  = (7'(e_pl) + 7'd1) >= 7'(cfg_i.plane_count);
  assign room       = cfg_i.image_columns - e_col;
  assign in_row     = e_col < cfg_i.image_columns;
  assign bit_n      = (room >= 15'(BITS_PER_BYTE)) ? BITS_PER_BYTE : room[3:0];
  assign rep_len    = (15'(rep_c) < room) ? rep_c : room[7:0];

  always_comb begin
    logic        emit;
    logic [7:0]  span_len;
    logic [7:0]  step;
    logic [3:0]  cnt;
    logic [7:0]  pix;
    logic [14:0] end_col;
    logic        fin;

    plane_d  = pl_c;
    row_d    = row_c;
    col_d    = col_c;
    phase_d  = phase_c;
    lit_d    = lit_c;
    rep_d    = rep_c;
    done_d   = done_c;
    emit     = 1'b0;
    span_len = 8'd1;
    step     = 8'd1;
    cnt      = 4'd1;
    pix      = b;

    if (!done_c) begin
      if (raw) begin
        plane_d = adv_pl;
        row_d   = adv_row;
        col_d   = adv_col;
        done_d  = adv_done;
        if (!adv_done) begin
          emit = 1'b1;
          if (cfg_i.one_bit_pixels) begin
            cnt  = bit_n;
            step = 8'(bit_n);
            pix  = b[7] ? PIX_SET_BIT : PIX_CLEAR_BIT;
          end
        end
      end else begin
        case (phase_c)
          PH_LITERAL: begin
            emit  = in_row;
            lit_d = (lit_c != 8'd0) ? lit_c - 8'd1 : lit_c;
            if (lit_d == 8'd0) phase_d = PH_HEADER;
          end
          PH_REPEAT: begin
            emit     = in_row && (rep_len != 8'd0);
            span_len = rep_len;
            step     = rep_len;
            rep_d    = '0;
            phase_d  = PH_HEADER;
          end
          default: begin
            phase_d = PH_HEADER;
            plane_d = adv_pl;
            row_d   = adv_row;
            col_d   = adv_col;
            done_d  = adv_done;
            if (!adv_done) begin
              if (b < HDR_NOOP) begin
                lit_d   = b + 8'd1;
                phase_d = PH_LITERAL;
              end else if (b > HDR_NOOP) begin
                rep_d   = 8'(REPEAT_BASE - 9'(b));
                phase_d = PH_REPEAT;
              end
            end
          end
        endcase
      end
    end

    end_col = e_col + 15'(step);
    fin     = (end_col >= cfg_i.image_columns) && e_row_last && e_pl_last;
    if (emit) begin
      col_d = end_col;
      if (fin) done_d = 1'b1;
    end

    job_valid_o = emit;
    job_o.row   = e_row;
    job_o.col   = e_col;
    job_o.len   = span_len;
    job_o.pix   = pix;
    job_o.tgt   = plane_target(cfg_i.chan_layout, e_pl);
    job_o.bits  = {b[6:0], 1'b0};
    job_o.count = cnt;
    job_o.done  = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      phase_q <= PH_HEADER;
      lit_q   <= '0;
      rep_q   <= '0;
      done_q  <= 1'b0;
    end else if (accept_i) begin
      plane_q <= plane_d;
      row_q   <= row_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
      done_q  <= done_d;
    end
  end

endmodule

>>> hdl/ppid_emitter.sv
// Result register that hands out the spans of one decoded word, one per cycle unless the output stalls.
module ppid_emitter import ppid_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      busy_o,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic busy_q, busy_d;
  job_t job_q, job_d;
  logic last;
  logic take;

  assign last = job_q.count == 4'd1;
  assign take = busy_q && !out_stall_i;

  // Room for a new word when empty or when the final span leaves now.
  assign free_o = !busy_q || (take && last);
  assign busy_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    if (accept_i && job_valid_i) begin
      busy_d = 1'b1;
      job_d  = job_i;
    end else if (take) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        job_d.col   = job_q.col + 15'd1;
        job_d.count = job_q.count - 4'd1;
        job_d.pix   = job_q.bits[7] ? PIX_SET_BIT : PIX_CLEAR_BIT;
        job_d.bits  = {job_q.bits[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign out_valid_o             = busy_q;
  assign out_data_o.row_index    = job_q.row;
  assign out_data_o.column_start = job_q.col;
  assign out_data_o.span_length  = job_q.len;
  assign out_data_o.pixel_value  = job_q.pix;
  assign out_data_o.target_kind  = job_q.tgt;
  assign out_data_o.image_done   = job_q.done && last;
  assign out_data_o.last_of_item = last;

endmodule

>>> hdl/planar_packbits_image_decoder_top.sv
// Top level of the planar raw / PackBits image data decoder.
//
// The block takes the image data section of a plane-ordered picture one byte
// per word, with the per-row length table already removed, and turns it into
// spans of equal pixels tagged with row, first column, length, value and the
// target that the current plane feeds under the programmed color mode. A
// byte is decoded in the cycle it is accepted and its spans wait in a result
// register, so the next byte is taken in the same cycle that the last span
// of the previous one leaves. Raw byte mode and PackBits therefore sustain
// one byte per cycle unless the output stalls; header bytes and bytes that
// write nothing produce no span. In raw one-bit mode a byte yields up to
// eight one-pixel spans, which the result register hands out one per cycle
// likewise. Repeat runs are clipped at the row end and literal bytes past
// it are dropped without a span. The user writes configuration through a
// plain write port only while the block is idle; the block does not enforce
// this. There is no clearing pass after reset. A word with first_byte set
// restarts position and run state before it is decoded.
module planar_packbits_image_decoder_top import ppid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o
);

`include "planar_packbits_image_decoder_top_assert.svh"

  // Configuration registers as written.
  logic        compression_q;
  logic        one_bit_q;
  logic [2:0]  chan_layout_q;
  logic [14:0] columns_q;
  logic [14:0] rows_q;
  logic [5:0]  planes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compression_q <= RST_COMPRESSION;
      one_bit_q     <= RST_ONE_BIT;
      chan_layout_q <= RST_CHAN_LAYOUT;
      columns_q     <= RST_COLUMNS;
      rows_q        <= RST_ROWS;
      planes_q      <= RST_PLANES;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COMPRESSION_MODE: compression_q <= cfg_data_i[0];
        REG_ONE_BIT_PIXELS:   one_bit_q     <= cfg_data_i[0];
        REG_CHAN_LAYOUT:      chan_layout_q <= cfg_data_i[2:0];
        REG_IMAGE_COLUMNS:    columns_q     <= cfg_data_i[14:0];
        REG_IMAGE_ROWS:       rows_q        <= cfg_data_i[14:0];
        REG_PLANE_COUNT:      planes_q      <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // A zero geometry value behaves as one.
  cfg_t cfg_eff;

  assign cfg_eff.compression_mode = compression_q;
  assign cfg_eff.one_bit_pixels   = one_bit_q;
  assign cfg_eff.chan_layout      = chan_layout_q;
  assign cfg_eff.image_columns    = (columns_q == '0) ? 15'd1 : columns_q;
  assign cfg_eff.image_rows       = (rows_q == '0) ? 15'd1 : rows_q;
  assign cfg_eff.plane_count      = (planes_q == '0) ? 6'd1 : planes_q;

  logic accept;
  logic job_valid;
  job_t job;
  logic emit_busy;
  logic emit_free;

  assign in_stall_o = !emit_free;
  assign accept     = in_valid_i && !in_stall_o;

  ppid_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_eff),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  ppid_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_valid_i (job_valid),
    .job_i       (job),
    .busy_o      (emit_busy),
    .free_o      (emit_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A span is never empty and never runs past the end of its row.
  `PPID_ASSERT_IMPL(a_span_in_row, emit_busy,
    (out_data_o.span_length != 8'd0) &&
    ((16'(out_data_o.column_start) + 16'(out_data_o.span_length)) <=
     16'(cfg_eff.image_columns)),
    "span empty or past the row end")

  // A stalled span holds still until it is taken.
  `PPID_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o),
    "stalled span changed or dropped")

  // The image is only finished on the last span of a word.
  `PPID_ASSERT_IMPL(a_done_is_last, out_valid_o && out_data_o.image_done,
    out_data_o.last_of_item,
    "image done flagged on an inner span")

  // Spans of one word walk along the same row, one column per span.
  `PPID_ASSERT_NEXT(a_bit_walk, out_valid_o && !out_stall_i && !out_data_o.last_of_item,
    out_valid_o && $stable(out_data_o.row_index) &&
    (out_data_o.column_start == $past(out_data_o.column_start) + 15'd1),
    "inner spans of a word do not follow each other")

endmodule
